// ----- sv/spq_pkg.sv -----
package spq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int ValueWidth        = 32;
  localparam int CountOutWidth     = 5;

  // Operation codes carried by the kind field.
  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic                         insert_en;
    logic                         remove_en;
    logic signed [ValueWidth-1:0] value;
  } spq_ctrl_t;

endpackage

// ----- sv/spq_cell.sv -----
module spq_cell (
  input  logic                                 clk_i,
  input  spq_pkg::spq_ctrl_t                   ctrl_i,
  input  logic                                 occupied_i,
  input  logic                                 left_gt_i,
  input  logic signed [spq_pkg::ValueWidth-1:0] left_entry_i,
  input  logic signed [spq_pkg::ValueWidth-1:0] right_entry_i,
  output logic                                 gt_o,
  output logic signed [spq_pkg::ValueWidth-1:0] entry_o,
  output logic signed [spq_pkg::ValueWidth-1:0] entry_d_o
);
  import spq_pkg::*;

  logic signed [ValueWidth-1:0] entry_q;
  logic signed [ValueWidth-1:0] entry_d;

  // An empty cell counts as greater, so the flags along the chain are monotone
  // and the first cell that raises its flag is where the new value lands.
  assign gt_o = !occupied_i || (entry_q > ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.remove_en) begin
      entry_d = right_entry_i;
    end else if (ctrl_i.insert_en) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o) begin
        entry_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

// ----- sv/sorted_priority_queue_unit.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_ready_o kind_i, value_i
// out      output     out_valid_o/ out_ready_i removed_value_o, underflow_o, overflow_o,
//                                             entry_count_o, front_value_o, queue_empty_o
//
// Every request is finished in the cycle it is accepted; its result appears in
// the output register in the next cycle, so one request per cycle is sustained
// while the result side is not stalled; the cell chain's compare-and-shift step allows this.
// Reset clears the entry count and the output valid; cell contents are not reset.
// A stalled result holds the output register; a new request is taken only when
// that register is empty or being emptied in the same cycle.
module sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic signed [spq_pkg::ValueWidth-1:0]  value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [spq_pkg::ValueWidth-1:0]  removed_value_o,
  output logic                                  underflow_o,
  output logic                                  overflow_o,
  output logic [spq_pkg::CountOutWidth-1:0]      entry_count_o,
  output logic signed [spq_pkg::ValueWidth-1:0]  front_value_o,
  output logic                                  queue_empty_o
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);

  logic                         in_fire;
  logic                         is_full;
  logic                         is_empty;
  spq_ctrl_t                    ctrl;
  logic [CW-1:0]                count_q;
  logic [CW-1:0]                count_d;
  logic [QUEUE_DEPTH-1:0]       gt;
  logic signed [ValueWidth-1:0] entry   [QUEUE_DEPTH];
  logic signed [ValueWidth-1:0] entry_d [QUEUE_DEPTH];

  logic                         out_valid_q;
  logic signed [ValueWidth-1:0] removed_q;
  logic                         under_q;
  logic                         over_q;
  logic [CW-1:0]                count_out_q;
  logic signed [ValueWidth-1:0] front_q;
  logic [CW+CountOutWidth-1:0]  count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == Full);
  assign is_empty   = (count_q == '0);

  assign ctrl.insert_en = in_fire && (kind_i == KindInsert) && !is_full;
  assign ctrl.remove_en = in_fire && (kind_i == KindRemove) && !is_empty;
  assign ctrl.value     = value_i;

  always_comb begin
    count_d = count_q;
    if (ctrl.insert_en) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.remove_en) begin
      count_d = count_q - 1'b1;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    logic                         left_gt;
    logic signed [ValueWidth-1:0] left_entry;
    logic signed [ValueWidth-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = entry[i];
    end else begin : g_mid
      assign left_gt    = gt[i-1];
      assign left_entry = entry[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (Idx < count_q),
      .left_gt_i    (left_gt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .gt_o         (gt[i]),
      .entry_o      (entry[i]),
      .entry_d_o    (entry_d[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      removed_q   <= ctrl.remove_en ? entry[0] : '0;
      under_q     <= (kind_i == KindRemove) && is_empty;
      over_q      <= (kind_i == KindInsert) && is_full;
      count_out_q <= count_d;
      front_q     <= (count_d != '0) ? entry_d[0] : '0;
    end
  end

  assign count_ext       = {{CountOutWidth{1'b0}}, count_out_q};
  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign underflow_o     = under_q;
  assign overflow_o      = over_q;
  assign entry_count_o   = count_ext[CountOutWidth-1:0];
  assign front_value_o   = front_q;
  assign queue_empty_o   = (count_out_q == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count exceeds queue depth");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CW'(2) |-> entry[0] <= entry[1])
    else $error("front cells out of order");

  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (kind_i == KindRemove) && is_empty |=> out_valid_q && under_q)
    else $error("remove on empty queue did not flag underflow");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert_en |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted insert did not grow the count");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(under_q && over_q))
    else $error("underflow and overflow raised together");

endmodule

// ----- dv/spq_result_checker.sv -----
module spq_result_checker #(
  parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic                                  kind_i,
  input  logic signed [spq_pkg::ValueWidth-1:0]  value_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic signed [spq_pkg::ValueWidth-1:0]  removed_value_i,
  input  logic                                  underflow_i,
  input  logic                                  overflow_i,
  input  logic [spq_pkg::CountOutWidth-1:0]      entry_count_i,
  input  logic signed [spq_pkg::ValueWidth-1:0]  front_value_i,
  input  logic                                  queue_empty_i,
  output int unsigned                           fail_count_o,
  output int unsigned                           pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  typedef struct {
    logic signed [ValueWidth-1:0] removed;
    logic                         underflow;
    logic                         overflow;
    logic [CountOutWidth-1:0]     count;
    logic signed [ValueWidth-1:0] front;
    logic                         empty;
  } queue_result_t;

  logic signed [ValueWidth-1:0] held_values [QUEUE_DEPTH];
  int                           held_count;
  queue_result_t                expected_results[$];
  queue_result_t                oldest;
  int unsigned                  mismatches;

  initial begin
    fail_count_o    = 0;
    pending_count_o = 0;
    mismatches      = 0;
    held_count      = 0;
  end

  // Applies one request to the local copy of the sorted list and returns the
  // result the block should report for it.
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic signed [ValueWidth-1:0] val);
    queue_result_t r;
    int            pos;
    r = '{removed: '0, underflow: 1'b0, overflow: 1'b0, count: '0, front: '0, empty: 1'b0};
    if (op == KindInsert) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        // The new value goes in front of the first strictly greater entry, so it
        // lands behind any equal ones.
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (held_values[i] > val) pos = i;
        end
        for (int i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
        held_values[pos] = val;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.underflow = 1'b1;
      end else begin
        r.removed = held_values[0];
        for (int i = 1; i < held_count; i++) held_values[i-1] = held_values[i];
        held_count--;
      end
    end
    r.count = CountOutWidth'(held_count);
    r.front = (held_count > 0) ? held_values[0] : '0;
    r.empty = (held_count == 0);
    return r;
  endfunction

  task automatic note_failure(input string what, input logic [ValueWidth-1:0] want,
                              input logic [ValueWidth-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [ValueWidth-1:0] want,
                             input logic [ValueWidth-1:0] got);
    if (want !== got) note_failure(what, want, got);
  endtask

  // The result is registered behind the request, so a result seen at
  // an edge never belongs to a request taken at that same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          note_failure("result with no request waiting", '0, removed_value_i);
        end else begin
          oldest = expected_results.pop_front();
          check_field("removed_value", oldest.removed, removed_value_i);
          check_field("underflow", ValueWidth'(oldest.underflow), ValueWidth'(underflow_i));
          check_field("overflow", ValueWidth'(oldest.overflow), ValueWidth'(overflow_i));
          check_field("entry_count", ValueWidth'(oldest.count), ValueWidth'(entry_count_i));
          check_field("front_value", oldest.front, front_value_i);
          check_field("queue_empty", ValueWidth'(oldest.empty), ValueWidth'(queue_empty_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_queue_op(kind_i, value_i));
      end
    end
    fail_count_o    <= mismatches;
    pending_count_o <= expected_results.size();
  end

endmodule

// ----- dv/sorted_priority_queue_unit_test.sv -----
module sorted_priority_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int RandomRequests = 1525;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_ready;
  logic                         kind;
  logic signed [ValueWidth-1:0] value;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [ValueWidth-1:0] removed_value;
  logic                         underflow;
  logic                         overflow;
  logic [CountOutWidth-1:0]     entry_count;
  logic signed [ValueWidth-1:0] front_value;
  logic                         queue_empty;
  int unsigned                  fail_count;
  int unsigned                  pending_count;
  bit                           no_idle;
  int                           insert_percent;

  sorted_priority_queue_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (kind),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .removed_value_o (removed_value),
    .underflow_o     (underflow),
    .overflow_o      (overflow),
    .entry_count_o   (entry_count),
    .front_value_o   (front_value),
    .queue_empty_o   (queue_empty)
  );

  spq_result_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .kind_i          (kind),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .removed_value_i (removed_value),
    .underflow_i     (underflow),
    .overflow_i      (overflow),
    .entry_count_i   (entry_count),
    .front_value_i   (front_value),
    .queue_empty_i   (queue_empty),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    kind      = KindInsert;
    value     = '0;
    out_ready = 1'b0;
    no_idle   = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [ValueWidth-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    // A narrow range produces plenty of equal values.
    if (r < 35) return ValueWidth'(int'($urandom_range(0, 16)) - 8);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // Valid stays high across back-to-back requests; it only drops for a gap.
  task automatic send_request(input logic op, input logic signed [ValueWidth-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= op;
    value    <= val;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Result side: mostly ready, with stalls of random length.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) stall_left = pick_gap() + 1;
      end
    end
  end

  initial begin
    logic op;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: remove from empty, fill with extremes and duplicates, insert
    // into a full queue, then take part of it back out.
    send_request(KindRemove, 32'sh1234_5678);
    send_request(KindInsert, 32'sh8000_0000);
    send_request(KindInsert, 32'sh7FFF_FFFF);
    send_request(KindInsert, 0);
    send_request(KindInsert, -1);
    send_request(KindInsert, 1);
    send_request(KindInsert, 5);
    send_request(KindInsert, 5);
    send_request(KindInsert, 5);
    send_request(KindInsert, -5);
    send_request(KindInsert, 32'sh5555_5555);
    send_request(KindInsert, 32'shAAAA_AAAA);
    send_request(KindInsert, 32'sh8000_0000);
    send_request(KindInsert, 32'sh7FFF_FFFF);
    send_request(KindInsert, 100);
    send_request(KindInsert, -100);
    send_request(KindInsert, 7);
    send_request(KindInsert, 3);
    repeat (7) send_request(KindRemove, pick_value());
    drain_results();

    // Random: the insert share changes every hundred requests so the queue
    // swings between full and empty.
    for (int n = 0; n < RandomRequests; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_percent = 85;
          1:       insert_percent = 50;
          default: insert_percent = 15;
        endcase
        no_idle = ($urandom_range(0, 4) == 0);
      end
      if (n % 500 == 499) drain_results();
      op = ($urandom_range(0, 99) < insert_percent) ? KindInsert : KindRemove;
      send_request(op, pick_value());
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
